FILE: rtl/pva_pkg.sv
// pva_pkg: shared types, constants and helpers for the polar vector adder
// holds the request and result structs, the arctangent table and the cordic cell payloads
// no dependencies
`default_nettype none

package pva_pkg;

	// field widths
	localparam int LEN_BITS   = 16;
	localparam int ANGLE_BITS = 16;

	// default depth of each cordic chain
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int MAX_STAGES        = 32;

	// internal angle is a 32-bit fraction of a turn
	localparam int TURN_BITS = 32;
	localparam int GUARD     = 16;

	// inverse cordic gain, 0.60725293500888 * 2^32
	localparam logic [31:0] KINV = 32'd2608131496;
	localparam logic [TURN_BITS-1:0] HALF_TURN = 32'h8000_0000;

	// datapath widths: cartesian parts and rotation-mode residual angle
	localparam int CW     = 37;
	localparam int RZW    = 34;
	localparam int PROD_W = LEN_BITS + 32;

	// atan(2^-i) as a fraction of a turn, scaled by 2^32
	localparam logic [31:0] ATAN_TURN [MAX_STAGES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	typedef logic signed [CW-1:0]  cval_t;
	typedef logic signed [RZW-1:0] rz_t;

	typedef struct packed {
		logic [LEN_BITS-1:0]          len_a;
		logic signed [ANGLE_BITS-1:0] angle_a;
		logic [LEN_BITS-1:0]          len_b;
		logic signed [ANGLE_BITS-1:0] angle_b;
	} pva_pair_t;

	typedef struct packed {
		logic [LEN_BITS:0]            sum_len;
		logic signed [ANGLE_BITS-1:0] sum_angle;
	} pva_sum_t;

	// one vector in the rotation chain
	typedef struct packed {
		cval_t x;
		cval_t y;
		rz_t   z;
	} pva_rvec_t;

	// what a rotation cell hands to its neighbour: both vectors of a request
	typedef struct packed {
		logic      valid;
		pva_rvec_t a;
		pva_rvec_t b;
	} pva_rot_t;

	// what a vectoring cell hands to its neighbour
	typedef struct packed {
		logic                 valid;
		logic                 zero;
		cval_t                x;
		cval_t                y;
		logic [TURN_BITS-1:0] z;
	} pva_vec_t;

	// shift right rounding toward zero: arithmetic shift, plus one when a
	// negative value loses set bits
	function automatic cval_t shr0(cval_t v, int s);
		logic [CW-1:0] mask;
		cval_t         r;
		mask = ~({CW{1'b1}} << s);
		r    = v >>> s;
		if (v[CW-1] && ((v & mask) != '0)) begin
			r = r + cval_t'(1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/pva_rot_cell.sv
// pva_rot_cell: one rotation-mode cordic micro-rotation for both vectors of a request
// depends on pva_pkg
`default_nettype none

module pva_rot_cell #(
	parameter int SHIFT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  pva_pkg::pva_rot_t src,
	output pva_pkg::pva_rot_t dst
);
	import pva_pkg::*;

	localparam rz_t ANG = rz_t'(ATAN_TURN[SHIFT]);

	logic      valid_q;
	pva_rvec_t a_q;
	pva_rvec_t b_q;

	// turn toward zero residual angle
	function automatic pva_rvec_t step(pva_rvec_t v);
		cval_t     dx;
		cval_t     dy;
		pva_rvec_t r;
		dx = shr0(v.y, SHIFT);
		dy = shr0(v.x, SHIFT);
		if (!v.z[RZW-1]) begin
			r.x = v.x - dx;
			r.y = v.y + dy;
			r.z = v.z - ANG;
		end else begin
			r.x = v.x + dx;
			r.y = v.y - dy;
			r.z = v.z + ANG;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_q <= step(src.a);
			b_q <= step(src.b);
		end
	end

	always_comb begin
		dst.valid = valid_q;
		dst.a     = a_q;
		dst.b     = b_q;
	end

endmodule

`default_nettype wire

FILE: rtl/pva_vec_cell.sv
// pva_vec_cell: one vectoring-mode cordic micro-rotation, accumulating the angle
// depends on pva_pkg
`default_nettype none

module pva_vec_cell #(
	parameter int SHIFT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  pva_pkg::pva_vec_t src,
	output pva_pkg::pva_vec_t dst
);
	import pva_pkg::*;

	localparam logic [TURN_BITS-1:0] ANG = ATAN_TURN[SHIFT];

	logic                 valid_q;
	logic                 zero_q;
	cval_t                x_q;
	cval_t                y_q;
	logic [TURN_BITS-1:0] z_q;
	cval_t                dx;
	cval_t                dy;

	assign dx = shr0(src.y, SHIFT);
	assign dy = shr0(src.x, SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= src.valid;
		end
	end

	// drive y toward zero, angle wraps modulo a turn
	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= src.zero;
			if (!src.y[CW-1]) begin
				x_q <= src.x + dx;
				y_q <= src.y - dy;
				z_q <= src.z + ANG;
			end else begin
				x_q <= src.x - dx;
				y_q <= src.y + dy;
				z_q <= src.z - ANG;
			end
		end
	end

	always_comb begin
		dst.valid = valid_q;
		dst.zero  = zero_q;
		dst.x     = x_q;
		dst.y     = y_q;
		dst.z     = z_q;
	end

endmodule

`default_nettype wire

FILE: rtl/polar_vector_add.sv
// polar_vector_add: top level, adds two polar vectors through two chains of cordic cells
// depends on pva_pkg, pva_rot_cell, pva_vec_cell
//
// usage
//  - pair channel (pair_valid, pair_stall, pair_data) carries one request: two vectors,
//    each an unsigned length and a signed binary angle (a full turn is 2^16)
//  - sum channel (sum_valid, sum_stall, sum_data) returns one result per request:
//    the magnitude (17 bits, same scale as the lengths) and the atan2 angle of the sum,
//    both zero when the sum is exactly zero
//  - a request passes stage 1 (gain multiply), stage 2, the rotation chain, stages 3
//    and 4, the vectoring chain, stage 5 (gain correction) and the output register
//  - throughput is one request per cycle while no result is held; the depth comes
//    from the two cordic chains, one cell per micro-rotation, plus those stages
//  - a finished result waits in the output register; while it is held with
//    sum_stall high the whole pipeline freezes and pair_stall is raised, otherwise
//    requests are taken every cycle even while results are in flight
//  - arst_n empties every stage; no result appears until a request is accepted
//  - results come out in request order, the block keeps no state between requests
`default_nettype none

module polar_vector_add #(
	parameter int CORDIC_STAGES = pva_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pair_valid,
	output logic               pair_stall,
	input  pva_pkg::pva_pair_t pair_data,
	output logic               sum_valid,
	input  logic               sum_stall,
	output pva_pkg::pva_sum_t  sum_data
);
	import pva_pkg::*;

	localparam int HI_W     = CW - 32;
	localparam int T_W      = HI_W + 33;
	localparam int ASH      = TURN_BITS - ANGLE_BITS;
	localparam logic [TURN_BITS-1:0] ANG_HALF = (ASH > 0) ? TURN_BITS'(1) << (ASH - 1) : '0;
	localparam logic [T_W-1:0]       LEN_MAX  = T_W'((64'd1 << (LEN_BITS + 1)) - 64'd1);

	// pipeline advances whenever the output register can move
	logic en;
	assign en         = !(sum_valid && sum_stall);
	assign pair_stall = !en;

	// ---- stage 1: gain multiply and quadrant fold ----
	logic                 valid_s1;
	logic [PROD_W-1:0]    prod_a_s1;
	logic [PROD_W-1:0]    prod_b_s1;
	logic                 flip_a_s1;
	logic                 flip_b_s1;
	rz_t                  za_s1;
	rz_t                  zb_s1;
	logic [TURN_BITS-1:0] th_a;
	logic [TURN_BITS-1:0] th_b;
	logic                 flip_a;
	logic                 flip_b;

	// angle as a fraction of a turn; left half plane is turned by half a turn
	always_comb begin
		th_a   = TURN_BITS'(unsigned'(pair_data.angle_a)) << ASH;
		th_b   = TURN_BITS'(unsigned'(pair_data.angle_b)) << ASH;
		flip_a = th_a[TURN_BITS-1] ^ th_a[TURN_BITS-2];
		flip_b = th_b[TURN_BITS-1] ^ th_b[TURN_BITS-2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pair_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_s1 <= PROD_W'(pair_data.len_a) * PROD_W'(KINV);
			prod_b_s1 <= PROD_W'(pair_data.len_b) * PROD_W'(KINV);
			flip_a_s1 <= flip_a;
			flip_b_s1 <= flip_b;
			za_s1     <= rz_t'(signed'({th_a[TURN_BITS-1] ^ flip_a, th_a[TURN_BITS-2:0]}));
			zb_s1     <= rz_t'(signed'({th_b[TURN_BITS-1] ^ flip_b, th_b[TURN_BITS-2:0]}));
		end
	end

	// ---- stage 2: rounded start value, negated for a folded angle ----
	logic              valid_s2;
	pva_rvec_t         va_s2;
	pva_rvec_t         vb_s2;
	logic [PROD_W-1:0] rnd_a;
	logic [PROD_W-1:0] rnd_b;
	cval_t             x0_a;
	cval_t             x0_b;

	always_comb begin
		rnd_a = (prod_a_s1 + (PROD_W'(1) << (31 - GUARD))) >> (32 - GUARD);
		rnd_b = (prod_b_s1 + (PROD_W'(1) << (31 - GUARD))) >> (32 - GUARD);
		x0_a  = cval_t'(rnd_a);
		x0_b  = cval_t'(rnd_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			va_s2.x <= flip_a_s1 ? -x0_a : x0_a;
			va_s2.y <= '0;
			va_s2.z <= za_s1;
			vb_s2.x <= flip_b_s1 ? -x0_b : x0_b;
			vb_s2.y <= '0;
			vb_s2.z <= zb_s1;
		end
	end

	// ---- rotation chain: polar to cartesian for both vectors ----
	pva_rot_t rot_link [CORDIC_STAGES+1];

	assign rot_link[0] = '{valid: valid_s2, a: va_s2, b: vb_s2};

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		pva_rot_cell #(
			.SHIFT(i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.src   (rot_link[i]),
			.dst   (rot_link[i+1])
		);
	end

	// ---- stage 3: sum of the cartesian parts ----
	logic  valid_s3;
	cval_t x_s3;
	cval_t y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= rot_link[CORDIC_STAGES].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3 <= rot_link[CORDIC_STAGES].a.x + rot_link[CORDIC_STAGES].b.x;
			y_s3 <= rot_link[CORDIC_STAGES].a.y + rot_link[CORDIC_STAGES].b.y;
		end
	end

	// ---- stage 4: zero detect, fold a sum with negative x into the right half ----
	logic                 valid_s4;
	logic                 zero_s4;
	cval_t                x_s4;
	cval_t                y_s4;
	logic [TURN_BITS-1:0] z_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s4 <= (x_s3 == '0) && (y_s3 == '0);
			if (x_s3[CW-1]) begin
				x_s4 <= -x_s3;
				y_s4 <= -y_s3;
				z_s4 <= HALF_TURN;
			end else begin
				x_s4 <= x_s3;
				y_s4 <= y_s3;
				z_s4 <= '0;
			end
		end
	end

	// ---- vectoring chain: magnitude and atan2 ----
	pva_vec_t vec_link [CORDIC_STAGES+1];

	assign vec_link[0] = '{valid: valid_s4, zero: zero_s4, x: x_s4, y: y_s4, z: z_s4};

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
		pva_vec_cell #(
			.SHIFT(i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.src   (vec_link[i]),
			.dst   (vec_link[i+1])
		);
	end

	// ---- stage 5: gain correction, split into a low and a high partial product ----
	logic                 valid_s5;
	logic                 zero_s5;
	logic [63:0]          lo_s5;
	logic [HI_W+31:0]     hi_s5;
	logic [TURN_BITS-1:0] z_s5;
	cval_t                x_end;

	assign x_end = vec_link[CORDIC_STAGES].x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= vec_link[CORDIC_STAGES].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s5 <= vec_link[CORDIC_STAGES].zero;
			z_s5    <= vec_link[CORDIC_STAGES].z;
			lo_s5   <= 64'(x_end[31:0]) * 64'(KINV);
			hi_s5   <= (HI_W + 32)'(x_end[CW-1:32]) * (HI_W + 32)'(KINV);
		end
	end

	// ---- output register: rounding, saturation, zero sum ----
	logic [T_W-1:0]       t_sum;
	logic [T_W-1:0]       len_rnd;
	logic [TURN_BITS-1:0] ang_rnd;
	logic                 sum_valid_q;
	pva_sum_t             sum_q;

	always_comb begin
		t_sum   = T_W'(hi_s5) + T_W'(lo_s5[63:32]);
		len_rnd = (t_sum + (T_W'(1) << (GUARD - 1))) >> GUARD;
		if (len_rnd > LEN_MAX) begin
			len_rnd = LEN_MAX;
		end
		ang_rnd = (z_s5 + ANG_HALF) >> ASH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid_q <= 1'b0;
		end else if (en) begin
			sum_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s5) begin
				sum_q <= '0;
			end else begin
				sum_q.sum_len   <= len_rnd[LEN_BITS:0];
				sum_q.sum_angle <= signed'(ang_rnd[ANGLE_BITS-1:0]);
			end
		end
	end

	assign sum_valid = sum_valid_q;
	assign sum_data  = sum_q;

endmodule

`default_nettype wire

FILE: rtl/pva_check.sv
// pva_check: port-level checks on the polar vector adder, attached by bind
// depends on pva_pkg and polar_vector_add
`default_nettype none

module pva_check (
	input logic              clk,
	input logic              arst_n,
	input logic              pair_stall,
	input logic              sum_valid,
	input logic              sum_stall,
	input pva_pkg::pva_sum_t sum_data
);
	import pva_pkg::*;

	// a held result stays put until taken
	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && sum_stall |=> sum_valid && $stable(sum_data))
		else $error("held result changed or dropped");

	// requests are refused only while a finished result is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall == (sum_valid && sum_stall))
		else $error("pair_stall does not follow the blocked output");

	// reset leaves no result behind
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !sum_valid)
		else $error("result present after reset");

endmodule

bind polar_vector_add pva_check u_pva_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.pair_stall(pair_stall),
	.sum_valid (sum_valid),
	.sum_stall (sum_stall),
	.sum_data  (sum_data)
);

`default_nettype wire
